/* rtl/efd_pkg.sv */
// Shared types and constants for the escaped frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

	// Start sequence and escape byte of the line format.
	localparam logic [7:0] START_B0 = 8'hA4;
	localparam logic [7:0] START_B1 = 8'h03;
	localparam logic [7:0] START_B2 = 8'h00;
	localparam logic [7:0] ESC_BYTE = 8'h1B;

	// Result kinds.
	localparam logic KIND_PAYLOAD   = 1'b0;
	localparam logic KIND_FRAME_END = 1'b1;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_HUNT0   = 4'd0,
		PH_HUNT1   = 4'd1,
		PH_HUNT2   = 4'd2,
		PH_SEQ     = 4'd3,
		PH_TYPE    = 4'd4,
		PH_LEN     = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CHK     = 4'd7
	} phase_t;

	// Parser state carried from one unescaped byte to the next.
	typedef struct packed {
		phase_t     phase;
		logic [7:0] running_sum;
		logic [7:0] hdr_seq;
		logic [7:0] hdr_type;
		logic [7:0] hdr_length;
		logic [7:0] payload_count;
	} pstate_t;

	// One result beat.
	typedef struct packed {
		logic       out_kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_seq;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic       checksum_ok;
		logic       run_last;
	} res_t;

endpackage

`default_nettype wire

/* rtl/efd_parse_step.sv */
// Frame parser update for one unescaped byte.
`timescale 1ns / 1ps
`default_nettype none

module efd_parse_step
	import efd_pkg::*;
(
	input  wire logic       en,
	input  wire logic [7:0] b,
	input  wire pstate_t    st,
	output pstate_t         st_next,
	output logic            res_valid,
	output res_t            res
);

	logic [7:0] sum_add;
	logic [7:0] count_inc;

	assign sum_add   = st.running_sum + b;
	assign count_inc = st.payload_count + 8'd1;

	// Next state and result for this byte.
	always_comb begin
		st_next            = st;
		res_valid          = 1'b0;
		res.out_kind       = KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.byte_index     = 8'd0;
		res.frame_seq      = st.hdr_seq;
		res.frame_type     = st.hdr_type;
		res.frame_length   = st.hdr_length;
		res.checksum_ok    = 1'b0;
		res.run_last       = 1'b0;
		if (en) begin
			unique case (st.phase)
				PH_HUNT1: begin
					if (b == START_B1) begin
						st_next.running_sum = sum_add;
						st_next.phase       = PH_HUNT2;
					end else if (b == START_B0) begin
						st_next.phase       = PH_HUNT1;
						st_next.running_sum = START_B0;
					end else begin
						st_next.phase       = PH_HUNT0;
						st_next.running_sum = 8'd0;
					end
				end
				PH_HUNT2: begin
					if (b == START_B2) begin
						st_next.running_sum = sum_add;
						st_next.phase       = PH_SEQ;
					end else if (b == START_B0) begin
						st_next.phase       = PH_HUNT1;
						st_next.running_sum = START_B0;
					end else begin
						st_next.phase       = PH_HUNT0;
						st_next.running_sum = 8'd0;
					end
				end
				PH_SEQ: begin
					st_next.hdr_seq     = b;
					st_next.running_sum = sum_add;
					st_next.phase       = PH_TYPE;
				end
				PH_TYPE: begin
					st_next.hdr_type    = b;
					st_next.running_sum = sum_add;
					st_next.phase       = PH_LEN;
				end
				PH_LEN: begin
					st_next.hdr_length    = b;
					st_next.running_sum   = sum_add;
					st_next.payload_count = 8'd0;
					st_next.phase         = (b == 8'd0) ? PH_CHK : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					st_next.running_sum   = sum_add;
					st_next.payload_count = count_inc;
					if (count_inc == st.hdr_length) begin
						st_next.phase = PH_CHK;
					end
					res_valid        = 1'b1;
					res.payload_byte = b;
					res.byte_index   = st.payload_count;
				end
				PH_CHK: begin
					// The checksum byte brings the total to zero mod 256.
					res_valid           = 1'b1;
					res.out_kind        = KIND_FRAME_END;
					res.checksum_ok     = ((b + st.running_sum) == 8'd0);
					st_next.phase       = PH_HUNT0;
					st_next.running_sum = 8'd0;
				end
				default: begin
					// Hunting for the first start byte.
					if (b == START_B0) begin
						st_next.phase       = PH_HUNT1;
						st_next.running_sum = START_B0;
					end else begin
						st_next.phase       = PH_HUNT0;
						st_next.running_sum = 8'd0;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/efd_out_queue.sv */
// Two-entry result register that takes up to two results per cycle.
`timescale 1ns / 1ps
`default_nettype none

module efd_out_queue
	import efd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  wire res_t       push0,
	input  wire res_t       push1,
	output logic [1:0]      space,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            out_res
);

	res_t       h0_q;
	res_t       h1_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] keep;

	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = h0_q;
	assign pop       = out_valid && out_ready;
	assign keep      = cnt_q - {1'b0, pop};
	assign space     = 2'd2 - keep;

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= keep + push_n;
		end
	end

	// Entries shift forward on a pop, and new results fill behind the kept ones.
	always_ff @(posedge clk) begin
		case (keep)
			2'd0: begin
				h0_q <= push0;
				h1_q <= push1;
			end
			2'd1: begin
				h0_q <= pop ? h1_q : h0_q;
				h1_q <= push0;
			end
			default: begin
				h0_q <= h0_q;
				h1_q <= h1_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/escaped_frame_deframer.sv */
// Top level of the escaped frame deframer.
//
//   Channel   Dir  tdata                                   tuser      tlast
//   s_axis    in   [7:0] rx_byte                           -          -
//   m_axis    out  payload, index, seq, type, length, ok   out_kind   run_last
//
// A received byte is registered, then unescaped and parsed combinationally, and its
// results land in a two-entry output register. One byte is taken per cycle while
// the output register has room and each byte yields at most one result; a byte that
// releases a held escape byte can yield two results, which take two output beats.
// The input register waits while the output register lacks room for its results.
// Reset clears the parser to hunting for the first start byte with no escape held.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_deframer
	import efd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] payload_byte, [15:8] byte_index, [23:16] frame_seq,
	// [31:24] frame_type, [39:32] frame_length, [40] checksum_ok, [47:41] zero
	output logic [47:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // [0] out_kind
	output logic             m_axis_tlast
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       esc_q;
	pstate_t    pst_q;

	pstate_t    pst_mid;
	pstate_t    pst_end;
	logic       v0;
	logic       v1;
	res_t       r0;
	res_t       r1;
	res_t       push0;
	res_t       push1;
	logic [1:0] nres;
	logic [1:0] push_n;
	logic [1:0] space;
	logic       fire;
	logic       en1;
	res_t       out_res;

	// A held escape byte goes to the parser first, then the new byte unless it is
	// itself an escape byte.
	assign en1 = (byte_s1 != ESC_BYTE);

	efd_parse_step u_step0 (
		.en        (esc_q),
		.b         (ESC_BYTE),
		.st        (pst_q),
		.st_next   (pst_mid),
		.res_valid (v0),
		.res       (r0)
	);

	efd_parse_step u_step1 (
		.en        (en1),
		.b         (byte_s1),
		.st        (pst_mid),
		.st_next   (pst_end),
		.res_valid (v1),
		.res       (r1)
	);

	// Pack the results in order and mark the last one of this byte.
	assign nres = {1'b0, v0} + {1'b0, v1};
	always_comb begin
		push0          = v0 ? r0 : r1;
		push0.run_last = !(v0 && v1);
		push1          = r1;
		push1.run_last = 1'b1;
	end

	assign fire          = valid_s1 && (nres <= space);
	assign push_n        = fire ? nres : 2'd0;
	assign s_axis_tready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Escape and parser state advance when the registered byte is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q               <= 1'b0;
			pst_q.phase         <= PH_HUNT0;
			pst_q.running_sum   <= 8'd0;
			pst_q.hdr_seq       <= 8'd0;
			pst_q.hdr_type      <= 8'd0;
			pst_q.hdr_length    <= 8'd0;
			pst_q.payload_count <= 8'd0;
		end else if (fire) begin
			esc_q <= (byte_s1 == ESC_BYTE) && !esc_q;
			pst_q <= pst_end;
		end
	end

	efd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (push0),
		.push1     (push1),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Output beat packing.
	assign m_axis_tdata = {7'd0, out_res.checksum_ok, out_res.frame_length,
		out_res.frame_type, out_res.frame_seq, out_res.byte_index, out_res.payload_byte};
	assign m_axis_tuser = out_res.out_kind;
	assign m_axis_tlast = out_res.run_last;

endmodule

`default_nettype wire

/* test/deframe_checker.sv */
// Checker that predicts the deframer's result beats and compares them on the fly.
`timescale 1ns / 1ps

module deframe_checker
	import efd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	output int               pending,
	output int               fail_count
);

	// Predicted deframer state.
	phase_t     ph;
	logic       esc_held;
	logic [7:0] sum_acc;
	logic [7:0] hdr_seq;
	logic [7:0] hdr_kind;
	logic [7:0] hdr_len;
	logic [7:0] pay_cnt;

	// Results still owed by the block, oldest first.
	res_t frame_results[$];
	res_t want;
	int   errors = 0;

	// A byte that breaks the start sequence restarts the hunt; A4 counts as a new start.
	task automatic restart_hunt(input logic [7:0] b);
		if (b == START_B0) begin
			ph = PH_HUNT1;
			sum_acc = START_B0;
		end else begin
			ph = PH_HUNT0;
			sum_acc = 8'h00;
		end
	endtask

	// Feeds one unescaped byte to the frame parser.
	task automatic parse_unescaped(input logic [7:0] b);
		res_t       r;
		logic [7:0] due;
		r = '0;
		r.frame_seq = hdr_seq;
		r.frame_type = hdr_kind;
		r.frame_length = hdr_len;
		case (ph)
			PH_HUNT1: begin
				if (b == START_B1) begin
					sum_acc = sum_acc + b;
					ph = PH_HUNT2;
				end else begin
					restart_hunt(b);
				end
			end
			PH_HUNT2: begin
				if (b == START_B2) begin
					sum_acc = sum_acc + b;
					ph = PH_SEQ;
				end else begin
					restart_hunt(b);
				end
			end
			PH_SEQ: begin
				hdr_seq = b;
				sum_acc = sum_acc + b;
				ph = PH_TYPE;
			end
			PH_TYPE: begin
				hdr_kind = b;
				sum_acc = sum_acc + b;
				ph = PH_LEN;
			end
			PH_LEN: begin
				hdr_len = b;
				sum_acc = sum_acc + b;
				pay_cnt = 8'h00;
				ph = (b == 8'h00) ? PH_CHK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_acc = sum_acc + b;
				r.out_kind = KIND_PAYLOAD;
				r.payload_byte = b;
				r.byte_index = pay_cnt;
				frame_results.push_back(r);
				pay_cnt = pay_cnt + 8'd1;
				if (pay_cnt == hdr_len)
					ph = PH_CHK;
			end
			PH_CHK: begin
				// The checksum byte must bring the whole frame sum to zero.
				due = 8'h00 - sum_acc;
				r.out_kind = KIND_FRAME_END;
				r.checksum_ok = (b == due);
				frame_results.push_back(r);
				ph = PH_HUNT0;
				sum_acc = 8'h00;
			end
			default: restart_hunt(b);
		endcase
	endtask

	// Undoes the escape doubling of one line byte and flags the last result it causes.
	task automatic deframe_raw(input logic [7:0] b);
		int   n_prior;
		res_t tail;
		n_prior = frame_results.size();
		if (b == ESC_BYTE && !esc_held) begin
			esc_held = 1'b1;
		end else begin
			if (esc_held) begin
				esc_held = 1'b0;
				parse_unescaped(ESC_BYTE);
			end
			if (b != ESC_BYTE)
				parse_unescaped(b);
		end
		if (frame_results.size() > n_prior) begin
			tail = frame_results.pop_back();
			tail.run_last = 1'b1;
			frame_results.push_back(tail);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Predict on every accepted input beat, compare on every accepted result beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_HUNT0;
			esc_held = 1'b0;
			sum_acc = 8'h00;
			hdr_seq = 8'h00;
			hdr_kind = 8'h00;
			hdr_len = 8'h00;
			pay_cnt = 8'h00;
			frame_results.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (s_tvalid && s_tready)
				deframe_raw(s_tdata);
			if (m_tvalid && m_tready) begin
				if (frame_results.size() == 0) begin
					$display("%0t: result beat with none expected, actual tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = frame_results.pop_front();
					check_field("out_kind", {7'd0, want.out_kind}, {7'd0, m_tuser});
					check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
					check_field("byte_index", want.byte_index, m_tdata[15:8]);
					check_field("frame_seq", want.frame_seq, m_tdata[23:16]);
					check_field("frame_type", want.frame_type, m_tdata[31:24]);
					check_field("frame_length", want.frame_length, m_tdata[39:32]);
					check_field("checksum_ok", {7'd0, want.checksum_ok}, {7'd0, m_tdata[40]});
					check_field("tdata padding", 8'h00, {1'b0, m_tdata[47:41]});
					check_field("run_last", {7'd0, want.run_last}, {7'd0, m_tlast});
				end
			end
			pending <= frame_results.size();
			fail_count <= errors;
		end
	end

endmodule

/* test/tb.sv */
// Testbench top for the escaped frame deframer: stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module tb;
	import efd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int         pending;
	int         fail_count;
	int         bytes_sent;
	bit         calm;
	logic [7:0] body_q[$];

	escaped_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	deframe_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.m_tlast    (m_axis_tlast),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #10 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#(10_000_000);
		$display("FAIL");
		$finish;
	end

	// Receiver stalls at random except during the calm stretch.
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
	end

	// Sends one line byte, with an occasional idle cycle before it.
	task automatic put_line(input logic [7:0] b);
		if (!calm && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Holds the sender back until every owed result has come out.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Sends a whole frame around body_q with escape doubling. A 1B that is followed by
	// another byte other than 1B may go out alone when lone_ok is set.
	task automatic put_frame(input logic [7:0] seq, input logic [7:0] kind,
			input bit corrupt, input bit lone_ok);
		logic [7:0] line_q[$];
		logic [7:0] sum;
		logic [7:0] chk;
		int         i;
		line_q.push_back(START_B0);
		line_q.push_back(START_B1);
		line_q.push_back(START_B2);
		line_q.push_back(seq);
		line_q.push_back(kind);
		line_q.push_back(8'(body_q.size()));
		foreach (body_q[j]) line_q.push_back(body_q[j]);
		sum = 8'h00;
		foreach (line_q[j]) sum = sum + line_q[j];
		chk = 8'h00 - sum;
		if (corrupt)
			chk = chk ^ 8'($urandom_range(1, 255));
		line_q.push_back(chk);
		for (i = 0; i < line_q.size(); i++) begin
			put_line(line_q[i]);
			if (line_q[i] == ESC_BYTE &&
					!(lone_ok && i + 1 < line_q.size() && line_q[i + 1] != ESC_BYTE))
				put_line(ESC_BYTE);
		end
		body_q.delete();
	endtask

	initial begin
		int         pick;
		int         len;
		int         k;
		logic [7:0] junk;

		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		calm = 1'b0;
		bytes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Escape run of three, released by a plain byte while hunting.
		put_line(ESC_BYTE);
		put_line(ESC_BYTE);
		put_line(ESC_BYTE);
		put_line(8'h55);
		// Broken start sequence; the frame's own A4 restarts the hunt.
		put_line(START_B0);
		put_line(START_B1);
		// Zero length frame whose sum is zero, so its checksum is zero too.
		put_frame(8'h59, 8'h00, 1'b0, 1'b0);
		// Lone escape in the payload gives two results from one byte; bad checksum.
		body_q.push_back(8'h00);
		body_q.push_back(ESC_BYTE);
		body_q.push_back(8'hFF);
		put_frame(8'hFF, 8'hFF, 1'b1, 1'b1);
		settle();

		// Random part: mostly well-formed frames, some broken headers and line noise.
		while (bytes_sent < 2000) begin
			calm <= (bytes_sent >= 900 && bytes_sent < 1300);
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					len = $urandom_range(0, 8);
				else if (pick < 96)
					len = $urandom_range(9, 40);
				else if (pick < 99)
					len = $urandom_range(41, 120);
				else
					len = 255;
				repeat (len) begin
					if ($urandom_range(0, 4) == 0)
						body_q.push_back(ESC_BYTE);
					else
						body_q.push_back(8'($urandom_range(0, 255)));
				end
				put_frame(8'($urandom), 8'($urandom), $urandom_range(0, 99) < 20,
					1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				// Header cut short.
				len = $urandom_range(1, 5);
				for (k = 0; k < len; k++) begin
					case (k)
						0: put_line(START_B0);
						1: put_line(START_B1);
						2: put_line(START_B2);
						default: put_line(8'($urandom));
					endcase
				end
			end else if (pick < 98) begin
				// Noise weighted toward the bytes that matter to the parser.
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 4))
						0: junk = START_B0;
						1: junk = START_B1;
						2: junk = START_B2;
						3: junk = ESC_BYTE;
						default: junk = 8'($urandom);
					endcase
					put_line(junk);
				end
			end else begin
				settle();
			end
		end

		// Drain and give the verdict.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/efd_pkg.sv
rtl/efd_parse_step.sv
rtl/efd_out_queue.sv
rtl/escaped_frame_deframer.sv
test/deframe_checker.sv
test/tb.sv
